>>> hdl/ppmd_pkg.sv
// Package for the PPM pulse train decoder: field widths, register map codes
// and the fixed reset values of the configuration registers. No dependencies.
package ppmd_pkg;

  localparam int unsigned TsW     = 25;  // timestamp and wrap period width
  localparam int unsigned GapW    = 16;  // max_gap and gap_offset width
  localparam int unsigned GainW   = 17;  // gain in unsigned Q16
  localparam int unsigned LimW    = 12;  // sync_limit and center_value width
  localparam int unsigned SlotW   = 4;   // slot output width
  localparam int unsigned ValW    = 16;  // channel value width
  localparam int unsigned DiffW   = 18;  // clamped gap minus offset, signed
  localparam int unsigned ProdW   = 36;  // signed product of diff and gain
  localparam int unsigned AddrW   = 5;   // APB byte address width
  localparam int unsigned DataW   = 32;  // APB data width
  localparam int unsigned RegIdxW = 3;   // register index within the map

  // Register indexes (byte address is four times the index).
  localparam logic [RegIdxW-1:0] RegWrapPeriod  = 3'd0;
  localparam logic [RegIdxW-1:0] RegMaxGap      = 3'd1;
  localparam logic [RegIdxW-1:0] RegGapOffset   = 3'd2;
  localparam logic [RegIdxW-1:0] RegGainQ16     = 3'd3;
  localparam logic [RegIdxW-1:0] RegSyncLimit   = 3'd4;
  localparam logic [RegIdxW-1:0] RegCenterValue = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [TsW-1:0]   WrapPeriodRst  = 25'd20000000;
  localparam logic [GapW-1:0]  MaxGapRst      = 16'd3500;
  localparam logic [GapW-1:0]  GapOffsetRst   = 16'd1103;
  localparam logic [GainW-1:0] GainQ16Rst     = 17'd64125;
  localparam logic [LimW-1:0]  SyncLimitRst   = 12'd800;
  localparam logic [LimW-1:0]  CenterValueRst = 12'd1500;

endpackage

>>> hdl/ppm_pulse_train_decoder_unit.sv
// PPM pulse train decoder top level: APB register file, three-stage datapath
// and output register. Depends on ppmd_pkg.
//
// This block turns timestamped edge events of a radio-control PPM train into
// channel values. A falling-edge beat (kind 0) records its timestamp and gives
// no result. A rising-edge beat (kind 1) measures the gap since the last
// falling edge, wrapping at wrap_period, saturates it to 16 bits signed and
// clamps it to max_gap, removes gap_offset and scales by gain_q16 (unsigned
// Q16). When the scaled width exceeds sync_limit in magnitude the slot counter
// restarts at zero. The result beat carries the slot and center_value plus the
// width, truncated toward zero and saturated to 16 bits signed; the slot then
// advances modulo CHANNELS. The block takes one beat per cycle unless its
// input is stalled. A rising-edge beat passes in order through the datapath
// pipeline: an input register, a difference register, a product register (the
// 18 x 18 multiplier sets this split) and the output register. Falling-edge
// beats never enter the pipeline. The input stalls only when all stages hold
// results and the output is stalled. Configuration is to be written through
// the APB port only while the block is idle; the block does not enforce it.
// pready is always high and register i sits at byte address 4*i.
module ppm_pulse_train_decoder_unit #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Edge event channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        kind_i,
  input  logic [ppmd_pkg::TsW-1:0]    timestamp_i,
  // Decoded channel output
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ppmd_pkg::SlotW-1:0]  slot_o,
  output logic signed [ppmd_pkg::ValW-1:0] channel_value_o,
  // APB configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ppmd_pkg::AddrW-1:0]  paddr,
  input  logic [ppmd_pkg::DataW-1:0]  pwdata,
  output logic [ppmd_pkg::DataW-1:0]  prdata,
  output logic                        pready
);
  import ppmd_pkg::*;

  localparam logic [SlotW:0] ChanCount = (SlotW+1)'(CHANNELS);

  // Configuration registers.
  logic [TsW-1:0]   wrap_period_q;
  logic [GapW-1:0]  max_gap_q;
  logic [GapW-1:0]  gap_offset_q;
  logic [GainW-1:0] gain_q16_q;
  logic [LimW-1:0]  sync_limit_q;
  logic [LimW-1:0]  center_value_q;

  logic               cfg_wr;
  logic [RegIdxW-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_period_q  <= WrapPeriodRst;
      max_gap_q      <= MaxGapRst;
      gap_offset_q   <= GapOffsetRst;
      gain_q16_q     <= GainQ16Rst;
      sync_limit_q   <= SyncLimitRst;
      center_value_q <= CenterValueRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegWrapPeriod:  wrap_period_q  <= pwdata[TsW-1:0];
        RegMaxGap:      max_gap_q      <= pwdata[GapW-1:0];
        RegGapOffset:   gap_offset_q   <= pwdata[GapW-1:0];
        RegGainQ16:     gain_q16_q     <= pwdata[GainW-1:0];
        RegSyncLimit:   sync_limit_q   <= pwdata[LimW-1:0];
        RegCenterValue: center_value_q <= pwdata[LimW-1:0];
        default: ;
      endcase
    end
  end

  // Read back, zero extended. Unmapped addresses read as zero.
  always_comb begin
    unique case (cfg_idx)
      RegWrapPeriod:  prdata = DataW'(wrap_period_q);
      RegMaxGap:      prdata = DataW'(max_gap_q);
      RegGapOffset:   prdata = DataW'(gap_offset_q);
      RegGainQ16:     prdata = DataW'(gain_q16_q);
      RegSyncLimit:   prdata = DataW'(sync_limit_q);
      RegCenterValue: prdata = DataW'(center_value_q);
      default:        prdata = '0;
    endcase
  end

  // Pipeline flow control. Each stage loads when it is empty or when the
  // stage after it loads, so bubbles are squeezed out under stall.
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic en_out, en3, en2, en1;
  logic in_acc;

  assign en_out     = !out_v_q || !out_stall_i;
  assign en3        = !s3_v_q || en_out;
  assign en2        = !s2_v_q || en3;
  assign en1        = !s1_v_q || en2;
  assign in_stall_o = !en1;
  assign in_acc     = in_valid_i && en1;

  // Falling edges update the stored timestamp at acceptance. A rising edge
  // carries a snapshot of it down the pipe, so a falling edge that follows
  // right behind cannot disturb the gap of the rising edge ahead of it.
  logic [TsW-1:0] fall_time_q;
  logic [TsW-1:0] s1_ts_q;
  logic [TsW-1:0] s1_fall_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fall_time_q <= '0;
    end else if (in_acc && !kind_i) begin
      fall_time_q <= timestamp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en1) begin
      s1_v_q <= in_acc && kind_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && kind_i) begin
      s1_ts_q   <= timestamp_i;
      s1_fall_q <= fall_time_q;
    end
  end

  // Stage 1: wrapped gap, saturation, clamp and offset removal.
  logic signed [TsW+1:0]  gap_raw;
  logic signed [GapW-1:0] gap_sat;
  logic signed [GapW-1:0] gap_clamp;
  logic signed [DiffW-1:0] diff_d;
  logic signed [DiffW-1:0] s2_diff_q;

  always_comb begin
    if (s1_ts_q >= s1_fall_q) begin
      gap_raw = $signed({2'b00, s1_ts_q}) - $signed({2'b00, s1_fall_q});
    end else begin
      gap_raw = $signed({2'b00, wrap_period_q}) + $signed({2'b00, s1_ts_q})
              - $signed({2'b00, s1_fall_q});
    end
    if (gap_raw > $signed((TsW+2)'(32767))) begin
      gap_sat = 16'sh7FFF;
    end else if (gap_raw < -$signed((TsW+2)'(32768))) begin
      gap_sat = -16'sh8000;
    end else begin
      gap_sat = gap_raw[GapW-1:0];
    end
    // max_gap is unsigned; compare in a wider signed domain.
    if ($signed({{2{gap_sat[GapW-1]}}, gap_sat}) > $signed({2'b00, max_gap_q})) begin
      gap_clamp = $signed(max_gap_q);
    end else begin
      gap_clamp = gap_sat;
    end
    diff_d = $signed({{2{gap_clamp[GapW-1]}}, gap_clamp})
           - $signed({2'b00, gap_offset_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en2) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && s1_v_q) begin
      s2_diff_q <= diff_d;
    end
  end

  // Stage 2: signed 18 x 18 multiply by the Q16 gain. Both factors are
  // extended to the product width so that no product bit is lost.
  logic signed [ProdW-1:0] wq_d;
  logic signed [ProdW-1:0] s3_wq_q;

  assign wq_d = $signed({{(ProdW-DiffW){s2_diff_q[DiffW-1]}}, s2_diff_q})
              * $signed({(ProdW-GainW)'(0), gain_q16_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en3) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && s2_v_q) begin
      s3_wq_q <= wq_d;
    end
  end

  // Stage 3: sync detection, centering with truncation toward zero,
  // saturation and slot bookkeeping.
  logic [ProdW-1:0]        wq_mag;
  logic [ProdW-1:0]        sync_lim;
  logic                    sync_hit;
  logic signed [ProdW:0]   sum;
  logic signed [ProdW-16:0] quo;
  logic signed [ValW-1:0]  val_d;
  logic [SlotW-1:0]        slot_index_q;
  logic [SlotW-1:0]        slot_d;
  logic [SlotW:0]          slot_inc;
  logic [SlotW-1:0]        slot_next;

  always_comb begin
    wq_mag   = s3_wq_q[ProdW-1] ? ProdW'(-s3_wq_q) : ProdW'(s3_wq_q);
    sync_lim = ProdW'({sync_limit_q, 16'h0000});
    sync_hit = wq_mag > sync_lim;

    sum = $signed({1'b0, ProdW'({center_value_q, 16'h0000})})
        + $signed({s3_wq_q[ProdW-1], s3_wq_q});
    quo = sum[ProdW:16];
    // An arithmetic shift floors; negative values with a fraction step up.
    if (sum[ProdW] && (sum[15:0] != 16'h0000)) begin
      quo = quo + (ProdW-15)'(1);
    end
    if (quo > $signed((ProdW-15)'(32767))) begin
      val_d = 16'sh7FFF;
    end else if (quo < -$signed((ProdW-15)'(32768))) begin
      val_d = -16'sh8000;
    end else begin
      val_d = quo[ValW-1:0];
    end

    slot_d    = sync_hit ? '0 : slot_index_q;
    slot_inc  = {1'b0, slot_d} + (SlotW+1)'(1);
    slot_next = (slot_inc >= ChanCount) ? '0 : slot_inc[SlotW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q      <= 1'b0;
      slot_index_q <= '0;
    end else if (en_out) begin
      out_v_q <= s3_v_q;
      if (s3_v_q) begin
        slot_index_q <= slot_next;
      end
    end
  end

  logic [SlotW-1:0]       slot_q;
  logic signed [ValW-1:0] value_q;

  always_ff @(posedge clk_i) begin
    if (en_out && s3_v_q) begin
      slot_q  <= slot_d;
      value_q <= val_d;
    end
  end

  assign out_valid_o     = out_v_q;
  assign slot_o          = slot_q;
  assign channel_value_o = value_q;

endmodule

>>> tb/tb_ppm_pulse_train_decoder_unit.sv
// Self-checking testbench for ppm_pulse_train_decoder_unit. It drives edge beats
// and APB register writes, predicts every decoded channel beat and checks it.
// Depends on ppmd_pkg and the decoder RTL.
module tb_ppm_pulse_train_decoder_unit;
  import ppmd_pkg::*;

  localparam int unsigned Channels    = 8;
  localparam int unsigned DrainCycles = 10;   // settle margin after the last channel beat
  localparam int unsigned HoldCycles  = 150;  // long receiver hold-off
  localparam int unsigned IdlePct     = 34;
  localparam int unsigned MaxPrinted  = 100;

  localparam logic EdgeFall = 1'b0;
  localparam logic EdgeRise = 1'b1;

  // Indexes past the register map; writes there must change nothing.
  localparam logic [RegIdxW-1:0] RegUnmapped6 = 3'd6;
  localparam logic [RegIdxW-1:0] RegUnmapped7 = 3'd7;

  localparam logic [TsW-1:0] TsMax = '1;

  typedef struct packed {
    logic [SlotW-1:0]        slot;
    logic signed [ValW-1:0]  value;
  } decoded_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic           in_valid  = 1'b0;
  logic           in_stall;
  logic           kind      = 1'b0;
  logic [TsW-1:0] timestamp = '0;

  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [SlotW-1:0]       slot;
  logic signed [ValW-1:0] channel_value;

  logic             psel    = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite  = 1'b0;
  logic [AddrW-1:0] paddr   = '0;
  logic [DataW-1:0] pwdata  = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  // Predictor copy of the configuration and of the decoder state.
  logic [TsW-1:0]   wrap_period_q  = WrapPeriodRst;
  logic [GapW-1:0]  max_gap_q      = MaxGapRst;
  logic [GapW-1:0]  gap_offset_q   = GapOffsetRst;
  logic [GainW-1:0] gain_q         = GainQ16Rst;
  logic [LimW-1:0]  sync_limit_q   = SyncLimitRst;
  logic [LimW-1:0]  center_q       = CenterValueRst;
  logic [TsW-1:0]   last_fall_ts   = '0;
  logic [SlotW-1:0] next_slot      = '0;

  decoded_t    pending_channels[$];
  int unsigned mismatches  = 0;
  int unsigned tx_idle_pct = IdlePct;
  int unsigned rx_idle_pct = IdlePct;
  logic        hold_go     = 1'b0;
  int unsigned hold_left   = 0;
  longint      timer_now   = 0;

  ppm_pulse_train_decoder_unit #(
    .CHANNELS(Channels)
  ) uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .kind_i         (kind),
    .timestamp_i    (timestamp),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .slot_o         (slot),
    .channel_value_o(channel_value),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    if (mismatches < MaxPrinted) $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic longint clip16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Falling edges only latch their timestamp. A rising edge measures the gap,
  // scales it and yields one channel beat for the current slot.
  function automatic void predict_edge(input logic k, input logic [TsW-1:0] ts);
    longint   t, f, w, gap, width_q16, mag, val;
    int       s;
    decoded_t d;
    if (k == EdgeFall) begin
      last_fall_ts = ts;
      return;
    end
    t = longint'(ts);
    f = longint'(last_fall_ts);
    w = longint'(wrap_period_q);
    if (t >= f) begin
      gap = t - f;
    end else begin
      gap = w + t - f;
    end
    gap = clip16(gap);
    if (gap > longint'(max_gap_q)) gap = longint'(max_gap_q);
    width_q16 = (gap - longint'(gap_offset_q)) * longint'(gain_q);
    mag = (width_q16 < 0) ? -width_q16 : width_q16;
    // A wide pulse is the frame sync: the slot counter restarts.
    if (mag > longint'(sync_limit_q) * 65536) next_slot = '0;
    val = clip16((longint'(center_q) * 65536 + width_q16) / 65536);
    d.slot  = next_slot;
    d.value = val[ValW-1:0];
    pending_channels.push_back(d);
    s = int'(next_slot) + 1;
    if (s >= Channels) s = 0;
    next_slot = s[SlotW-1:0];
  endfunction

  // One APB write: setup cycle, access cycle, then a free cycle so that the
  // next write never drives psel twice in one step.
  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [DataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegWrapPeriod:  wrap_period_q = data[TsW-1:0];
      RegMaxGap:      max_gap_q     = data[GapW-1:0];
      RegGapOffset:   gap_offset_q  = data[GapW-1:0];
      RegGainQ16:     gain_q        = data[GainW-1:0];
      RegSyncLimit:   sync_limit_q  = data[LimW-1:0];
      RegCenterValue: center_q      = data[LimW-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_all_regs(input logic [DataW-1:0] wrap, input logic [DataW-1:0] maxg,
                                input logic [DataW-1:0] offs, input logic [DataW-1:0] gain,
                                input logic [DataW-1:0] synl, input logic [DataW-1:0] ctr);
    write_reg(RegWrapPeriod, wrap);
    write_reg(RegMaxGap, maxg);
    write_reg(RegGapOffset, offs);
    write_reg(RegGainQ16, gain);
    write_reg(RegSyncLimit, synl);
    write_reg(RegCenterValue, ctr);
  endtask

  task automatic write_default_regs();
    write_all_regs(DataW'(WrapPeriodRst), DataW'(MaxGapRst), DataW'(GapOffsetRst),
                   DataW'(GainQ16Rst), DataW'(SyncLimitRst), DataW'(CenterValueRst));
  endtask

  // Sends one edge beat. Valid is only lowered while idling, so back-to-back
  // beats keep it high without a second assignment in the same step.
  task automatic send_edge(input logic k, input logic [TsW-1:0] ts);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid  <= 1'b0;
      kind      <= 1'($urandom_range(1));
      timestamp <= TsW'($urandom());
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    timestamp <= ts;
    do @(posedge clk); while (in_stall);
    predict_edge(k, ts);
  endtask

  // Waits until every channel beat has arrived, then lets the pipeline settle
  // so that trailing falling edges are done before any register write.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_channels.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Mostly well-formed falling/rising pairs with PPM-like gaps: channel
  // pulses, oversize pulses, clamped frame syncs and wrap crossings. About a
  // ninth of the beats are noise with random kind and timestamp.
  task automatic drive_pulse_mix(input int unsigned count);
    int unsigned sent;
    int unsigned pick;
    longint      w, gap, rise_t;
    sent = 0;
    w = longint'(wrap_period_q);
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        send_edge(1'($urandom_range(1)), TsW'($urandom()));
        sent++;
      end else begin
        if (pick < 65) begin
          gap = longint'($urandom_range(1900, 300));
        end else if (pick < 77) begin
          gap = longint'($urandom_range(2600, 1900));
        end else if (pick < 87) begin
          gap = longint'($urandom_range(5000, 2600));
        end else begin
          gap = longint'($urandom_range(20000, 5000));
        end
        timer_now = timer_now % w;
        if ($urandom_range(9) == 0 && w > 20000) begin
          timer_now = w - longint'($urandom_range(20000, 1));
        end
        rise_t = (timer_now + gap) % w;
        send_edge(EdgeFall, timer_now[TsW-1:0]);
        send_edge(EdgeRise, rise_t[TsW-1:0]);
        sent += 2;
        timer_now = (rise_t + longint'($urandom_range(600, 200))) % w;
      end
    end
  endtask

  // Reset values: a rise before any fall, plain, wrapped and clamped gaps,
  // timestamps past the wrap period, repeated falls and repeated rises.
  task automatic test_default_edges();
    send_edge(EdgeRise, TsW'(1500));
    send_edge(EdgeFall, TsW'(1000));
    send_edge(EdgeRise, TsW'(2500));
    send_edge(EdgeFall, TsW'(19999600));
    send_edge(EdgeRise, TsW'(500));
    send_edge(EdgeFall, TsW'(20000100));
    send_edge(EdgeRise, TsW'(20001200));
    send_edge(EdgeFall, TsMax);
    send_edge(EdgeRise, TsMax);
    send_edge(EdgeFall, TsW'(0));
    send_edge(EdgeRise, TsW'(30000));
    send_edge(EdgeRise, TsW'(30900));
    send_edge(EdgeFall, TsW'(100));
    send_edge(EdgeFall, TsW'(200));
    send_edge(EdgeRise, TsW'(1300));
    drain();
  endtask

  // Register extremes: all-low settings with a negative wrapped gap, then
  // over-wide writes that leave every field at its maximum, writes to
  // unmapped indexes, and both ends of the output saturation.
  task automatic test_register_extremes();
    write_all_regs(1, 0, 0, 0, 0, 0);
    send_edge(EdgeFall, TsMax);
    send_edge(EdgeRise, TsW'(0));
    send_edge(EdgeFall, TsW'(0));
    send_edge(EdgeRise, TsMax);
    drain();
    write_all_regs('1, '1, '1, '1, '1, '1);
    write_reg(RegUnmapped6, $urandom());
    write_reg(RegUnmapped7, $urandom());
    send_edge(EdgeFall, TsW'(10));
    send_edge(EdgeRise, TsW'(10));
    send_edge(EdgeFall, TsW'(0));
    send_edge(EdgeRise, TsW'(40000));
    drain();
    write_reg(RegGapOffset, 0);
    send_edge(EdgeFall, TsMax);
    send_edge(EdgeRise, TsW'(40000));
    send_edge(EdgeRise, TsMax);
    drain();
  endtask

  task automatic test_random_default();
    write_default_regs();
    drive_pulse_mix(300);
    drain();
  endtask

  // Neither side idles here, so beats run at full rate through the pipeline.
  task automatic test_no_idle_stretch();
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    drive_pulse_mix(150);
    drain();
    tx_idle_pct = IdlePct;
    rx_idle_pct <= IdlePct;
  endtask

  // Settings near the usual ones, so that sync resets stay occasional.
  task automatic test_random_jittered_config();
    repeat (2) begin
      write_all_regs($urandom_range(TsMax, 1000000), $urandom_range(6000, 2000),
                     $urandom_range(1400, 800), $urandom_range(80000, 50000),
                     $urandom_range(1000, 500), $urandom_range(2000, 1000));
      drive_pulse_mix(125);
      drain();
    end
  endtask

  // Arbitrary settings; the unused upper bits of each write are random too.
  task automatic test_random_wild_config();
    logic [DataW-1:0] wrap;
    repeat (2) begin
      wrap = $urandom();
      wrap[TsW-1:0] = TsW'($urandom_range(TsMax, 1));
      write_all_regs(wrap, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      drive_pulse_mix(125);
      drain();
    end
  endtask

  // A short wrap period makes wrapped and negative gaps the common case.
  task automatic test_small_wrap_period();
    write_all_regs($urandom_range(4000, 1), DataW'(MaxGapRst), DataW'(GapOffsetRst),
                   DataW'(GainQ16Rst), DataW'(SyncLimitRst), DataW'(CenterValueRst));
    drive_pulse_mix(200);
    drain();
  endtask

  // The receiver holds off for a long stretch while rising edges keep
  // coming, so the pipeline fills and the block stalls its input.
  task automatic test_backpressure_fill();
    write_default_regs();
    tx_idle_pct = 0;
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    send_edge(EdgeFall, TsW'(1000));
    repeat (48) send_edge(EdgeRise, TsW'(1000 + $urandom_range(1900, 300)));
    drain();
    tx_idle_pct = IdlePct;
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_go) hold_left = HoldCycles;
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Every accepted channel beat is matched against the oldest prediction.
  always @(posedge clk) begin : check_channels
    decoded_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_channels.size() == 0) begin
        report_mismatch($sformatf("unexpected beat: slot %0d value %0d", slot,
                                  channel_value));
      end else begin
        want = pending_channels.pop_front();
        if (slot !== want.slot)
          report_mismatch($sformatf("slot %0d, expected %0d", slot, want.slot));
        if (channel_value !== want.value)
          report_mismatch($sformatf("value %0d, expected %0d (slot %0d)", channel_value,
                                    want.value, want.slot));
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_edges();
    test_register_extremes();
    test_random_default();
    test_no_idle_stretch();
    test_random_jittered_config();
    test_random_wild_config();
    test_small_wrap_period();
    test_backpressure_fill();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
